// File: rtl/cal_rtc_pkg.sv
// Shared constants, field offsets and state type of the calibrated RTC timekeeper.
`default_nettype none

package cal_rtc_pkg;

    localparam int FRAC_BITS     = 12;

    localparam int TICK_W        = 32;
    localparam int SEC_W         = 32;
    localparam int US_W          = 20;
    localparam int CAL_W         = 32;
    localparam int BASE_W        = 64;
    localparam int TZ_W          = 5;
    localparam int REG_W         = 5;

    localparam int PROD_W        = BASE_W + CAL_W;
    localparam int DVD_W         = PROD_W - FRAC_BITS;
    localparam int CNT_W         = $clog2(DVD_W);
    localparam int OFF_W         = 18;

    localparam int IN_FIELDS_W   = TICK_W + SEC_W + US_W + CAL_W;
    localparam int S_TDATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W  = SEC_W + US_W;
    localparam int M_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int TICK_LSB      = 0;
    localparam int SEC_LSB       = TICK_LSB + TICK_W;
    localparam int US_LSB        = SEC_LSB + SEC_W;
    localparam int CAL_LSB       = US_LSB + US_W;

    localparam logic [CAL_W-1:0] USEC_PER_SEC  = 32'd1000000;
    localparam int               SECS_PER_HOUR = 3600;

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_TIMEZONE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_DAYLIGHT = 1'b1;

    localparam logic CMD_READ   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULT_T,
        S_TOTAL,
        S_DIV_BASE,
        S_ELAPSED,
        S_MULT_E,
        S_LOAD_US,
        S_DIV_US,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

// File: rtl/calibrated_rtc_timekeeper_top.sv
// Calibrated RTC timekeeper: tick counter to wall time with serial multiply and divide.
//
//  channel   direction  fields (lowest bit up)
//  s_axis    in         tuser: cmd; tdata: tick_count, seconds_in, micros_in, calibration_in
//  m_axis    out        tdata: seconds_out, micros_out
//  i_cfg     in         index 0 timezone_hours, index 1 daylight_on
//
// A read runs S_ELAPSED, S_MULT_E, S_LOAD_US, S_DIV_US, S_EMIT; an update first runs
// S_MULT_T, S_TOTAL, S_DIV_BASE. A new transaction is taken in the cycle after the
// output register is loaded. It uses the bit-serial shift-add multiplier (32 steps) and
// the restoring divider (one quotient bit a cycle, 64 steps for the tick base).
// Reset is synchronous, active low, and restores tick base 0 and calibration 1.
// A stalled output holds the result; the next transaction may be accepted meanwhile.
`default_nettype none

module calibrated_rtc_timekeeper_top (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tick_count, seconds_in, micros_in, calibration_in, zero pad
    input  wire  [cal_rtc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // cmd
    input  wire                                   s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // seconds_out, micros_out, zero pad
    output logic [cal_rtc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  wire                                   i_cfg_we,
    input  wire  [cal_rtc_pkg::REG_IDX_W-1:0]     i_cfg_addr,
    input  wire  [cal_rtc_pkg::REG_W-1:0]         i_cfg_wdata
);

    cal_rtc_pkg::t_state r_state, n_state;

    logic [cal_rtc_pkg::BASE_W-1:0] r_base, n_base;
    logic [cal_rtc_pkg::TICK_W-1:0] r_ref, n_ref;
    logic [cal_rtc_pkg::TICK_W-1:0] r_last, n_last;
    logic [cal_rtc_pkg::CAL_W-1:0]  r_cal, n_cal;
    logic [cal_rtc_pkg::TZ_W-1:0]   r_tz, n_tz;
    logic                           r_dl, n_dl;

    logic [cal_rtc_pkg::TICK_W-1:0] r_count, n_count;
    logic [cal_rtc_pkg::US_W-1:0]   r_us, n_us;

    logic [cal_rtc_pkg::BASE_W-1:0] r_mcand, n_mcand;
    logic [cal_rtc_pkg::BASE_W-1:0] r_mhi, n_mhi;
    logic [cal_rtc_pkg::CAL_W-1:0]  r_mlo, n_mlo;

    logic [cal_rtc_pkg::DVD_W-1:0]  r_dvd, n_dvd;
    logic [cal_rtc_pkg::CAL_W-1:0]  r_dvs, n_dvs;
    logic [cal_rtc_pkg::CAL_W-1:0]  r_rem, n_rem;
    logic [cal_rtc_pkg::BASE_W-1:0] r_quo, n_quo;

    logic [cal_rtc_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    logic                           r_out_valid, n_out_valid;
    logic [cal_rtc_pkg::SEC_W-1:0]  r_out_sec, n_out_sec;
    logic [cal_rtc_pkg::US_W-1:0]   r_out_us, n_out_us;

    logic                           s_accept;
    logic [cal_rtc_pkg::TICK_W-1:0] in_tick;
    logic [cal_rtc_pkg::SEC_W-1:0]  in_sec;
    logic [cal_rtc_pkg::US_W-1:0]   in_us;
    logic [cal_rtc_pkg::CAL_W-1:0]  in_cal;
    logic [cal_rtc_pkg::CAL_W-1:0]  in_cal_fix;

    logic signed [cal_rtc_pkg::TZ_W:0]    tz_sum;
    logic signed [cal_rtc_pkg::OFF_W-1:0] off_sec;
    logic [cal_rtc_pkg::SEC_W-1:0]        off_ext;
    logic [cal_rtc_pkg::SEC_W-1:0]        t_corr;

    logic [cal_rtc_pkg::BASE_W:0]         mul_sum;
    logic [cal_rtc_pkg::CAL_W:0]          div_part;
    logic [cal_rtc_pkg::CAL_W+1:0]        div_diff;
    logic                                 div_ge;
    logic [cal_rtc_pkg::CAL_W-1:0]        div_rem;
    logic [cal_rtc_pkg::BASE_W-1:0]       quo_next;

    logic [cal_rtc_pkg::BASE_W-1:0]       prod_t;
    logic [cal_rtc_pkg::BASE_W-1:0]       tot_sum;
    logic [cal_rtc_pkg::BASE_W-1:0]       total;
    logic [cal_rtc_pkg::BASE_W-1:0]       elapsed;
    logic [cal_rtc_pkg::PROD_W-1:0]       prod_e;

    assign s_axis_tready = (r_state == cal_rtc_pkg::S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_tick = s_axis_tdata[cal_rtc_pkg::TICK_LSB +: cal_rtc_pkg::TICK_W];
    assign in_sec  = s_axis_tdata[cal_rtc_pkg::SEC_LSB  +: cal_rtc_pkg::SEC_W];
    assign in_us   = s_axis_tdata[cal_rtc_pkg::US_LSB   +: cal_rtc_pkg::US_W];
    assign in_cal  = s_axis_tdata[cal_rtc_pkg::CAL_LSB  +: cal_rtc_pkg::CAL_W];
    // zero calibration would stop the clock: substitute one
    assign in_cal_fix = (in_cal == '0) ? cal_rtc_pkg::CAL_W'(1) : in_cal;

    // timezone plus daylight hours, in seconds, applied modulo 2^32
    assign tz_sum  = signed'({r_tz[cal_rtc_pkg::TZ_W-1], r_tz})
                   + signed'({{cal_rtc_pkg::TZ_W{1'b0}}, r_dl});
    assign off_sec = cal_rtc_pkg::OFF_W'(tz_sum)
                   * cal_rtc_pkg::OFF_W'(cal_rtc_pkg::SECS_PER_HOUR);
    assign off_ext = {{(cal_rtc_pkg::SEC_W - cal_rtc_pkg::OFF_W){off_sec[cal_rtc_pkg::OFF_W-1]}},
                      off_sec};
    assign t_corr  = in_sec + off_ext;

    // shift-add multiplier step: multiplier bits leave the low word as product bits enter
    assign mul_sum = {1'b0, r_mhi} + (r_mlo[0] ? {1'b0, r_mcand} : '0);

    // restoring divider step: one quotient bit per cycle
    assign div_part = {r_rem, r_dvd[cal_rtc_pkg::DVD_W-1]};
    assign div_diff = {1'b0, div_part} - {2'b00, r_dvs};
    assign div_ge   = !div_diff[cal_rtc_pkg::CAL_W+1];
    assign div_rem  = div_ge ? div_diff[cal_rtc_pkg::CAL_W-1:0]
                             : div_part[cal_rtc_pkg::CAL_W-1:0];
    assign quo_next = {r_quo[cal_rtc_pkg::BASE_W-2:0], div_ge};

    assign prod_t  = {r_mhi[cal_rtc_pkg::BASE_W-cal_rtc_pkg::CAL_W-1:0], r_mlo};
    assign tot_sum = prod_t + cal_rtc_pkg::BASE_W'(r_us);
    assign total   = {tot_sum[cal_rtc_pkg::BASE_W-cal_rtc_pkg::FRAC_BITS-1:0],
                      {cal_rtc_pkg::FRAC_BITS{1'b0}}};
    assign elapsed = r_base + cal_rtc_pkg::BASE_W'(r_count) - cal_rtc_pkg::BASE_W'(r_ref);
    assign prod_e  = {r_mhi, r_mlo};

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_ref       = r_ref;
        n_last      = r_last;
        n_cal       = r_cal;
        n_tz        = r_tz;
        n_dl        = r_dl;
        n_count     = r_count;
        n_us        = r_us;
        n_mcand     = r_mcand;
        n_mhi       = r_mhi;
        n_mlo       = r_mlo;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_sec   = r_out_sec;
        n_out_us    = r_out_us;

        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cal_rtc_pkg::REG_TIMEZONE: n_tz = i_cfg_wdata[cal_rtc_pkg::TZ_W-1:0];
                cal_rtc_pkg::REG_DAYLIGHT: n_dl = i_cfg_wdata[0];
                default: ;
            endcase
        end

        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            cal_rtc_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_last  = in_tick;
                    n_count = in_tick;
                    // counter wrapped since the last transaction
                    if (in_tick < r_last) begin
                        n_base = r_base + (cal_rtc_pkg::BASE_W'(1) << cal_rtc_pkg::TICK_W);
                    end
                    if (s_axis_tuser == cal_rtc_pkg::CMD_UPDATE) begin
                        n_cal   = in_cal_fix;
                        n_ref   = in_tick;
                        n_us    = in_us;
                        n_mcand = cal_rtc_pkg::BASE_W'(cal_rtc_pkg::USEC_PER_SEC);
                        n_mhi   = '0;
                        n_mlo   = t_corr;
                        n_cnt   = cal_rtc_pkg::CNT_W'(cal_rtc_pkg::CAL_W - 1);
                        n_state = cal_rtc_pkg::S_MULT_T;
                    end else begin
                        n_state = cal_rtc_pkg::S_ELAPSED;
                    end
                end
            end
            cal_rtc_pkg::S_MULT_T: begin
                n_mhi = mul_sum[cal_rtc_pkg::BASE_W:1];
                n_mlo = {mul_sum[0], r_mlo[cal_rtc_pkg::CAL_W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = cal_rtc_pkg::S_TOTAL;
                end
            end
            cal_rtc_pkg::S_TOTAL: begin
                n_dvd   = {total, {(cal_rtc_pkg::DVD_W - cal_rtc_pkg::BASE_W){1'b0}}};
                n_dvs   = r_cal;
                n_rem   = '0;
                n_cnt   = cal_rtc_pkg::CNT_W'(cal_rtc_pkg::BASE_W - 1);
                n_state = cal_rtc_pkg::S_DIV_BASE;
            end
            cal_rtc_pkg::S_DIV_BASE: begin
                n_rem = div_rem;
                n_dvd = {r_dvd[cal_rtc_pkg::DVD_W-2:0], 1'b0};
                n_quo = quo_next;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_base  = quo_next;
                    n_state = cal_rtc_pkg::S_ELAPSED;
                end
            end
            cal_rtc_pkg::S_ELAPSED: begin
                n_mcand = elapsed;
                n_mhi   = '0;
                n_mlo   = r_cal;
                n_cnt   = cal_rtc_pkg::CNT_W'(cal_rtc_pkg::CAL_W - 1);
                n_state = cal_rtc_pkg::S_MULT_E;
            end
            cal_rtc_pkg::S_MULT_E: begin
                n_mhi = mul_sum[cal_rtc_pkg::BASE_W:1];
                n_mlo = {mul_sum[0], r_mlo[cal_rtc_pkg::CAL_W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = cal_rtc_pkg::S_LOAD_US;
                end
            end
            cal_rtc_pkg::S_LOAD_US: begin
                // drop the fraction bits of the Q product
                n_dvd   = prod_e[cal_rtc_pkg::PROD_W-1:cal_rtc_pkg::FRAC_BITS];
                n_dvs   = cal_rtc_pkg::USEC_PER_SEC;
                n_rem   = '0;
                n_cnt   = cal_rtc_pkg::CNT_W'(cal_rtc_pkg::DVD_W - 1);
                n_state = cal_rtc_pkg::S_DIV_US;
            end
            cal_rtc_pkg::S_DIV_US: begin
                n_rem = div_rem;
                n_dvd = {r_dvd[cal_rtc_pkg::DVD_W-2:0], 1'b0};
                n_quo = quo_next;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = cal_rtc_pkg::S_EMIT;
                end
            end
            cal_rtc_pkg::S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_sec   = r_quo[cal_rtc_pkg::SEC_W-1:0];
                    n_out_us    = r_rem[cal_rtc_pkg::US_W-1:0];
                    n_state     = cal_rtc_pkg::S_IDLE;
                end
            end
            default: n_state = cal_rtc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cal_rtc_pkg::S_IDLE;
            r_base      <= '0;
            r_ref       <= '0;
            r_last      <= '0;
            r_cal       <= cal_rtc_pkg::CAL_W'(1);
            r_tz        <= '0;
            r_dl        <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_ref       <= n_ref;
            r_last      <= n_last;
            r_cal       <= n_cal;
            r_tz        <= n_tz;
            r_dl        <= n_dl;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count   <= n_count;
        r_us      <= n_us;
        r_mcand   <= n_mcand;
        r_mhi     <= n_mhi;
        r_mlo     <= n_mlo;
        r_dvd     <= n_dvd;
        r_dvs     <= n_dvs;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_out_sec <= n_out_sec;
        r_out_us  <= n_out_us;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = cal_rtc_pkg::M_TDATA_W'({r_out_us, r_out_sec});

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !s_axis_tready)
        else $error("input accepted twice without finishing the transaction");

    a_micros_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_out_us < cal_rtc_pkg::USEC_PER_SEC[cal_rtc_pkg::US_W-1:0]))
        else $error("microsecond result not below one second");

    a_cal_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal != '0)
        else $error("stored calibration is zero");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cal_rtc_pkg::S_EMIT && (!r_out_valid || m_axis_tready))
        |=> (m_axis_tvalid && r_state == cal_rtc_pkg::S_IDLE))
        else $error("finished result not moved to the output register");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the calibrated RTC timekeeper top level.
`timescale 1ns / 1ps

module tb;
    import cal_rtc_pkg::*;

    typedef struct packed {
        logic              cmd;
        logic [TICK_W-1:0] tick;
        logic [SEC_W-1:0]  secs;
        logic [US_W-1:0]   usec;
        logic [CAL_W-1:0]  cal;
    } t_sample;

    typedef struct packed {
        logic [SEC_W-1:0] secs;
        logic [US_W-1:0]  usec;
    } t_wall;

    // Predicts wall time per accepted transaction and compares what the block returns.
    class time_scoreboard;
        bit [BASE_W-1:0]        tick_base;
        bit [TICK_W-1:0]        ref_count;
        bit [TICK_W-1:0]        last_count;
        bit [CAL_W-1:0]         cal = 1;
        bit signed [TZ_W-1:0]   tz_hours;
        bit                     dst;
        t_wall                  wall_q[$];
        int                     mismatches;
        int                     n_reads;
        int                     n_updates;
        int                     n_wraps;
        int                     n_checked;

        function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
            if (idx == REG_TIMEZONE)
                tz_hours = val[TZ_W-1:0];
            else
                dst = val[0];
        endfunction

        function void note_input(input t_sample it);
            int               offset;
            bit [SEC_W-1:0]   local_secs;
            bit [BASE_W-1:0]  total;
            bit [BASE_W-1:0]  elapsed;
            bit [PROD_W-1:0]  prod;
            bit [PROD_W-1:0]  usec_total;
            t_wall            w;
            // a count below the last one means the counter has wrapped
            if (it.tick < last_count) begin
                tick_base += 64'h1_0000_0000;
                n_wraps++;
            end
            last_count = it.tick;
            if (it.cmd == CMD_UPDATE) begin
                n_updates++;
                offset = (int'(tz_hours) + int'(dst)) * SECS_PER_HOUR;
                local_secs = it.secs + SEC_W'(offset);
                cal = (it.cal == '0) ? CAL_W'(1) : it.cal;
                ref_count = it.tick;
                total = (BASE_W'(it.usec) + BASE_W'(local_secs) * BASE_W'(USEC_PER_SEC))
                        << FRAC_BITS;
                tick_base = total / BASE_W'(cal);
            end else begin
                n_reads++;
            end
            elapsed = tick_base + BASE_W'(it.tick) - BASE_W'(ref_count);
            prod = PROD_W'(elapsed) * PROD_W'(cal);
            usec_total = prod >> FRAC_BITS;
            w.secs = SEC_W'(usec_total / PROD_W'(USEC_PER_SEC));
            w.usec = US_W'(usec_total % PROD_W'(USEC_PER_SEC));
            wall_q.push_back(w);
        endfunction

        function void check_result(input logic [SEC_W-1:0] secs, input logic [US_W-1:0] usec);
            t_wall want;
            n_checked++;
            if (wall_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result with nothing pending: secs=%0d usec=%0d",
                             $realtime, secs, usec);
                return;
            end
            want = wall_q.pop_front();
            if (secs !== want.secs) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: seconds_out expected %0d got %0d",
                             $realtime, want.secs, secs);
            end
            if (usec !== want.usec) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: micros_out expected %0d got %0d",
                             $realtime, want.usec, usec);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = CMD_READ;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0]   i_cfg_addr = REG_TIMEZONE;
    logic [REG_W-1:0]       i_cfg_wdata = '0;

    time_scoreboard sb = new;
    bit             calm;
    logic [TICK_W-1:0] tick_now;
    int             n_settings;

    calibrated_rtc_timekeeper_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // stall the result side now and then
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[SEC_W-1:0], m_axis_tdata[SEC_W +: US_W]);
    end

    task automatic send_item(input t_sample it);
        if (!calm && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 240)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= S_TDATA_W'({it.cal, it.usec, it.secs, it.tick});
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(it);
    endtask

    task automatic send_fields(input logic cmd, input logic [TICK_W-1:0] tick,
                               input logic [SEC_W-1:0] secs, input logic [US_W-1:0] usec,
                               input logic [CAL_W-1:0] cal);
        t_sample it;
        it = '{cmd: cmd, tick: tick, secs: secs, usec: usec, cal: cal};
        tick_now = tick;
        send_item(it);
    endtask

    // free-running counter with the odd jump and backward step
    task automatic make_item(output t_sample it);
        int r;
        r = $urandom_range(99);
        if (r < 70)
            tick_now += $urandom_range(1, 1 << 22);
        else if (r < 85)
            tick_now += $urandom();
        else if (r < 93)
            tick_now -= $urandom_range(0, 1000);
        else
            tick_now = $urandom();
        it.tick = tick_now;
        it.cmd = ($urandom_range(99) < 30) ? CMD_UPDATE : CMD_READ;
        r = $urandom_range(99);
        it.secs = (r < 3) ? '0 : (r < 6) ? '1 : $urandom();
        it.usec = ($urandom_range(99) < 85) ? US_W'($urandom_range(0, 999999))
                                            : US_W'($urandom_range(1000000, 1048575));
        r = $urandom_range(99);
        if (r < 60)
            it.cal = $urandom_range(2048, 8192);
        else if (r < 75)
            it.cal = $urandom();
        else if (r < 85)
            it.cal = $urandom_range(1, 16);
        else if (r < 90)
            it.cal = '0;
        else
            it.cal = '1;
    endtask

    // drop valid and wait for every pending result before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.wall_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    initial begin
        t_sample it;
        int      tz_set[6];
        bit      dst_set[6];
        tz_set  = '{-11, 13, 13, 0, -16, 15};
        dst_set = '{1, 0, 1, 1, 0, 1};
        tick_now = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: extremes, wraps, zero calibration, oversized microseconds
        send_fields(CMD_READ,   32'd0,          32'd0,          20'd0,      32'd0);
        send_fields(CMD_READ,   '1,             '1,             '1,         '1);
        send_fields(CMD_READ,   32'd5,          32'd0,          20'd0,      32'd0);
        send_fields(CMD_UPDATE, 32'd100,        32'd0,          20'd0,      32'd4096);
        send_fields(CMD_READ,   32'd1000100,    32'd0,          20'd0,      32'd0);
        send_fields(CMD_UPDATE, 32'd2000000,    32'd1700000000, 20'd999999, 32'd4096);
        send_fields(CMD_READ,   32'd2500000,    32'd0,          20'd0,      32'd0);
        send_fields(CMD_UPDATE, 32'd2600000,    32'd1234,       '1,         32'd0);
        send_fields(CMD_READ,   32'd2600100,    32'd0,          20'd0,      32'd0);
        send_fields(CMD_UPDATE, 32'd50,         32'd1000,       20'd500000, 32'd4096);
        send_fields(CMD_READ,   32'd40,         32'd0,          20'd0,      32'd0);
        send_fields(CMD_UPDATE, 32'd0,          '1,             20'd999999, 32'd1);
        send_fields(CMD_READ,   '1,             32'd0,          20'd0,      32'd0);
        send_fields(CMD_READ,   32'd1,          32'd0,          20'd0,      32'd0);
        send_fields(CMD_UPDATE, 32'd7,          '1,             '1,         '1);
        send_fields(CMD_READ,   32'hFFFFFFF0,   32'd0,          20'd0,      32'd0);
        send_fields(CMD_UPDATE, 32'd8,          32'd86400,      20'd1,      32'd2048);
        send_fields(CMD_READ,   32'd8,          32'd0,          20'd0,      32'd0);
        send_fields(CMD_UPDATE, 32'd9,          32'd0,          20'd0,      32'd1);
        send_fields(CMD_READ,   32'd9,          32'd0,          20'd0,      32'd0);
        n_settings = 1;

        for (int p = 0; p < 6; p++) begin
            drain();
            write_reg(REG_TIMEZONE, REG_W'(tz_set[p]));
            write_reg(REG_DAYLIGHT, REG_W'(dst_set[p]));
            n_settings++;
            calm = (p == 2);
            // offsets that push the corrected seconds below zero or past the top
            send_fields(CMD_UPDATE, tick_now + 32'd10, 32'd0, 20'd0, 32'd4096);
            send_fields(CMD_UPDATE, tick_now + 32'd10, '1, 20'd999999, 32'd4096);
            repeat (280) begin
                make_item(it);
                send_item(it);
            end
        end
        calm = 1'b0;

        drain();
        repeat (250) @(posedge i_clk);
        $display("covered %0d reads and %0d updates, %0d counter wraps, %0d register settings",
                 sb.n_reads, sb.n_updates, sb.n_wraps, n_settings);
        $display("%0d results compared, %0d mismatches, %0d left pending",
                 sb.n_checked, sb.mismatches, sb.wall_q.size());
        if (sb.mismatches == 0 && sb.wall_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
